@@ hdl/pfd_pkg.sv @@
// Shared types and constants for the PWM frequency and duty register calculator.
package pfd_pkg;

   // Field widths of the request and result beats.
   localparam int FREQ_W     = 32;
   localparam int DUTY_W     = 17;
   localparam int STATUS_W   = 2;
   localparam int PRESCALE_W = 6;
   localparam int PERIOD_W   = 10;
   localparam int DCOUNT_W   = 11;

   // Duty is an unsigned 1.16 fraction; full scale means always high.
   localparam int DUTY_FRAC_BITS = 16;
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(65536);

   // Reset value of the source clock register.
   localparam logic [FREQ_W-1:0] CLOCK_RESET_HZ = FREQ_W'(12800000);

   // Shared divider operand width and step counter width.
   localparam int DIV_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [STATUS_W-1:0] status_type;

   // Result status codes.
   localparam status_type STATUS_OK             = 2'd0;
   localparam status_type STATUS_ZERO_FREQ      = 2'd1;
   localparam status_type STATUS_ABOVE_CLOCK    = 2'd2;
   localparam status_type STATUS_PRESCALE_RANGE = 2'd3;

   // One classified request as it waits in the queue.
   typedef struct packed {
      status_type         status;
      logic [FREQ_W-1:0]  frequency;
      logic [DUTY_W-1:0]  duty;
   } req_entry_type;

   // Divider command and answer.
   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [DIV_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_W-1:0]   quotient;
   } div_rsp_type;

endpackage

@@ hdl/pfd_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module pfd_div (
   input  logic                clock,
   input  logic                reset,
   input  pfd_pkg::div_req_type div_req,
   output pfd_pkg::div_rsp_type div_rsp
);
   import pfd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_W:0]       rem_shift;
   logic [DIV_W+1:0]     diff;
   logic                 fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[DIV_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
      fits      = ~diff[DIV_W+1];
   end

   // Step control and datapath next values.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start && !busy_ff) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DIV_W-2:0], fits};
         rem_in   = fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

`ifndef SYNTHESIS
   // A finished quotient only follows a division that was running.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider signaled done without a running division");
`endif

endmodule

@@ hdl/pfd_queue.sv @@
// Short queue of classified requests between the front and back ends.
module pfd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pfd_pkg::req_entry_type push_entry,
   input  logic                   pop,
   output pfd_pkg::req_entry_type head_entry,
   output logic                   empty,
   output logic                   full
);
   import pfd_pkg::*;

   req_entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = entries_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   // The fill count never passes the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   // The back end never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");
`endif

endmodule

@@ hdl/pfd_front.sv @@
// Front end: accepts requests, rejects bad frequencies and saturates the duty.
module pfd_front (
   input  logic                              start,
   output logic                              busy,
   input  logic [pfd_pkg::FREQ_W-1:0]        req_request_frequency,
   input  logic [pfd_pkg::DUTY_W-1:0]        req_request_duty,
   input  logic [pfd_pkg::FREQ_W-1:0]        clock_hz,
   input  logic                              queue_full,
   output logic                              push,
   output pfd_pkg::req_entry_type            push_entry
);
   import pfd_pkg::*;

   // A request is taken whenever the queue has room.
   assign busy = queue_full;
   assign push = start && !queue_full;

   // Classify the frequency and clip the duty to full scale.
   always_comb begin
      push_entry.frequency = req_request_frequency;
      push_entry.duty      = (req_request_duty > DUTY_FULL) ? DUTY_FULL : req_request_duty;
      if (req_request_frequency == '0) begin
         push_entry.status = STATUS_ZERO_FREQ;
      end else if (req_request_frequency > clock_hz) begin
         push_entry.status = STATUS_ABOVE_CLOCK;
      end else begin
         push_entry.status = STATUS_OK;
      end
   end

endmodule

@@ hdl/pfd_back.sv @@
// Back end: runs the two divisions, prescaler step and duty multiply of each valid request.
module pfd_back #(
   parameter int PERIOD_LIMIT   = 1024,
   parameter int PRESCALE_LIMIT = 63
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pfd_pkg::FREQ_W-1:0]        clock_hz,
   input  pfd_pkg::req_entry_type            head_entry,
   input  logic                              queue_empty,
   output logic                              pop,
   output pfd_pkg::div_req_type              div_req,
   input  pfd_pkg::div_rsp_type              div_rsp,
   output logic                              rsp_strobe,
   output logic [pfd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pfd_pkg::PRESCALE_W-1:0]    rsp_prescale_value,
   output logic [pfd_pkg::PERIOD_W-1:0]      rsp_period_minus_one,
   output logic [pfd_pkg::DCOUNT_W-1:0]      rsp_duty_count
);
   import pfd_pkg::*;

   localparam int PER_W  = $clog2(PERIOD_LIMIT + 1);
   localparam int PROD_W = PER_W + DUTY_W;

   // The prescaler is (cycles - 1) over the period limit, done as a multiply by the
   // rounded-up reciprocal; for any 32-bit dividend the shifted product is exact.
   localparam int RECIP_SHIFT = DIV_W + $clog2(PERIOD_LIMIT);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(PERIOD_LIMIT) - 64'd1) / 64'(PERIOD_LIMIT);
   localparam int RECIP_LO_W = 16;
   localparam int RECIP_HI_W = DIV_W + 1 - RECIP_LO_W;
   localparam int LO_PROD_W  = DIV_W + RECIP_LO_W;
   localparam int HI_PROD_W  = DIV_W + RECIP_HI_W;
   localparam int SUM_W      = HI_PROD_W + RECIP_LO_W;
   localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_FULL[RECIP_LO_W-1:0];
   localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_FULL[DIV_W:RECIP_LO_W];

   // Sequencer states.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DIV_CYC = 3'd1;
   localparam logic [2:0] S_PRE_MUL = 3'd2;
   localparam logic [2:0] S_PRE_SUM = 3'd3;
   localparam logic [2:0] S_DIV_PER = 3'd4;
   localparam logic [2:0] S_MUL     = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  div_start_ff, div_start_in;
   logic [DIV_W-1:0]      div_dividend_ff, div_dividend_in;
   logic [DIV_W-1:0]      div_divisor_ff, div_divisor_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic [DIV_W-1:0]      cycles_ff, cycles_in;
   logic [DIV_W-1:0]      cycles_m1_ff, cycles_m1_in;
   logic [LO_PROD_W-1:0]  recip_lo_ff, recip_lo_in;
   logic [HI_PROD_W-1:0]  recip_hi_ff, recip_hi_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [PER_W-1:0]      period_ff, period_in;
   logic [PROD_W-1:0]     product_ff, product_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [PRESCALE_W-1:0] rsp_prescale_ff, rsp_prescale_in;
   logic [PERIOD_W-1:0]   rsp_period_ff, rsp_period_in;
   logic [DCOUNT_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [DIV_W-1:0]      period_m1_wide;
   logic [63:0]           duty_wide;
   logic [SUM_W-1:0]      recip_sum;
   logic [SUM_W-1:0]      recip_shifted;
   logic [DIV_W-1:0]      prescale_q;

   // Final field arithmetic on the stored period and product.
   always_comb begin
      period_m1_wide = DIV_W'(period_ff) - DIV_W'(1);
      duty_wide      = 64'(product_ff) >> DUTY_FRAC_BITS;
   end

   // Recombine the two reciprocal partial products into the prescaler.
   always_comb begin
      recip_sum     = {recip_hi_ff, {RECIP_LO_W{1'b0}}} + SUM_W'(recip_lo_ff);
      recip_shifted = recip_sum >> RECIP_SHIFT;
      prescale_q    = recip_shifted[DIV_W-1:0];
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in        = state_ff;
      div_start_in    = 1'b0;
      div_dividend_in = div_dividend_ff;
      div_divisor_in  = div_divisor_ff;
      duty_in         = duty_ff;
      cycles_in       = cycles_ff;
      cycles_m1_in    = cycles_m1_ff;
      recip_lo_in     = recip_lo_ff;
      recip_hi_in     = recip_hi_ff;
      prescale_in     = prescale_ff;
      period_in       = period_ff;
      product_in      = product_ff;
      rsp_strobe_in   = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_prescale_in = rsp_prescale_ff;
      rsp_period_in   = rsp_period_ff;
      rsp_duty_in     = rsp_duty_ff;
      pop             = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head_entry.status != STATUS_OK) begin
                  // Rejected at the front: report the code with zero fields.
                  rsp_strobe_in   = 1'b1;
                  rsp_status_in   = head_entry.status;
                  rsp_prescale_in = '0;
                  rsp_period_in   = '0;
                  rsp_duty_in     = '0;
               end else begin
                  // Total cycle count is the source clock over the frequency.
                  duty_in         = head_entry.duty;
                  div_start_in    = 1'b1;
                  div_dividend_in = clock_hz;
                  div_divisor_in  = head_entry.frequency;
                  state_in        = S_DIV_CYC;
               end
            end
         end
         S_DIV_CYC: begin
            if (div_rsp.done) begin
               cycles_in    = div_rsp.quotient;
               cycles_m1_in = div_rsp.quotient - DIV_W'(1);
               state_in     = S_PRE_MUL;
            end
         end
         S_PRE_MUL: begin
            // Partial products of (cycles - 1) with the reciprocal halves.
            recip_lo_in = LO_PROD_W'(cycles_m1_ff) * LO_PROD_W'(RECIP_LO);
            recip_hi_in = HI_PROD_W'(cycles_m1_ff) * HI_PROD_W'(RECIP_HI);
            state_in    = S_PRE_SUM;
         end
         S_PRE_SUM: begin
            if (prescale_q > DIV_W'(PRESCALE_LIMIT)) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = STATUS_PRESCALE_RANGE;
               rsp_prescale_in = '0;
               rsp_period_in   = '0;
               rsp_duty_in     = '0;
               state_in        = S_IDLE;
            end else begin
               // Period is the cycle count over the chosen divider.
               prescale_in     = prescale_q[PRESCALE_W-1:0];
               div_start_in    = 1'b1;
               div_dividend_in = cycles_ff;
               div_divisor_in  = prescale_q + DIV_W'(1);
               state_in        = S_DIV_PER;
            end
         end
         S_DIV_PER: begin
            if (div_rsp.done) begin
               // Clamp the period to one through the period limit.
               if (div_rsp.quotient == '0) begin
                  period_in = PER_W'(1);
               end else if (div_rsp.quotient > DIV_W'(PERIOD_LIMIT)) begin
                  period_in = PER_W'(PERIOD_LIMIT);
               end else begin
                  period_in = div_rsp.quotient[PER_W-1:0];
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            product_in = PROD_W'(period_ff) * PROD_W'(duty_ff);
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_strobe_in   = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_prescale_in = prescale_ff;
            rsp_period_in   = period_m1_wide[PERIOD_W-1:0];
            rsp_duty_in     = duty_wide[DCOUNT_W-1:0];
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_start_ff  <= div_start_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      div_dividend_ff <= div_dividend_in;
      div_divisor_ff  <= div_divisor_in;
      duty_ff         <= duty_in;
      cycles_ff       <= cycles_in;
      cycles_m1_ff    <= cycles_m1_in;
      recip_lo_ff     <= recip_lo_in;
      recip_hi_ff     <= recip_hi_in;
      prescale_ff     <= prescale_in;
      period_ff       <= period_in;
      product_ff      <= product_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_prescale_ff <= rsp_prescale_in;
      rsp_period_ff   <= rsp_period_in;
      rsp_duty_ff     <= rsp_duty_in;
   end

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = div_dividend_ff;
   assign div_req.divisor  = div_divisor_ff;

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_prescale_value   = rsp_prescale_ff;
   assign rsp_period_minus_one = rsp_period_ff;
   assign rsp_duty_count       = rsp_duty_ff;

`ifndef SYNTHESIS
   // A division is only launched while the divider is free.
   assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> !div_rsp.busy)
      else $error("division launched while the divider is busy");

   // A rejected request always carries zero register values.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != STATUS_OK) |->
         (rsp_prescale_ff == '0 && rsp_period_ff == '0 && rsp_duty_ff == '0))
      else $error("error result with nonzero register values");
`endif

endmodule

@@ hdl/pwm_frequency_duty_to_registers.sv @@
// Top level of the PWM frequency and duty to timer register calculator.
// A valid request runs two 32-step divisions on the one divider, a request whose prescaler
// is out of range only the first, and one that the front rejects none; the back end
// finishes each request before it takes the next; the front takes a beat while its two-entry
// queue has room, and results never stall.
// Reset is synchronous: it empties the queue, idles the back end and restores 12800000 Hz.
module pwm_frequency_duty_to_registers #(
   parameter int PERIOD_LIMIT   = 1024,
   parameter int PRESCALE_LIMIT = 63
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pfd_pkg::FREQ_W-1:0]        req_request_frequency,
   input  logic [pfd_pkg::DUTY_W-1:0]        req_request_duty,
   output logic                              rsp_strobe,
   output logic [pfd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pfd_pkg::PRESCALE_W-1:0]    rsp_prescale_value,
   output logic [pfd_pkg::PERIOD_W-1:0]      rsp_period_minus_one,
   output logic [pfd_pkg::DCOUNT_W-1:0]      rsp_duty_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pfd_pkg::FREQ_W-1:0]        csr_source_clock_hz
);
   import pfd_pkg::*;

   logic [FREQ_W-1:0] clock_hz_ff, clock_hz_in;
   logic              queue_push;
   logic              queue_pop;
   logic              queue_empty;
   logic              queue_full;
   req_entry_type     push_entry;
   req_entry_type     head_entry;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // Source clock register; a write beat is taken in any cycle.
   assign csr_ready   = 1'b1;
   assign clock_hz_in = (csr_valid && csr_ready) ? csr_source_clock_hz : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET_HZ;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   pfd_front u_front (
      .start                 (start),
      .busy                  (busy),
      .req_request_frequency (req_request_frequency),
      .req_request_duty      (req_request_duty),
      .clock_hz              (clock_hz_ff),
      .queue_full            (queue_full),
      .push                  (queue_push),
      .push_entry            (push_entry)
   );

   pfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   pfd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pfd_back #(
      .PERIOD_LIMIT   (PERIOD_LIMIT),
      .PRESCALE_LIMIT (PRESCALE_LIMIT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .clock_hz             (clock_hz_ff),
      .head_entry           (head_entry),
      .queue_empty          (queue_empty),
      .pop                  (queue_pop),
      .div_req              (div_req),
      .div_rsp              (div_rsp),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_prescale_value   (rsp_prescale_value),
      .rsp_period_minus_one (rsp_period_minus_one),
      .rsp_duty_count       (rsp_duty_count)
   );

endmodule

@@ tb/sv/pwm_frequency_duty_to_registers_test.sv @@
// Self-checking testbench for the PWM frequency and duty to timer register calculator.
`timescale 1ns / 100ps

module pwm_frequency_duty_to_registers_test;
   import pfd_pkg::*;

   localparam int PERIOD_LIMIT   = 1024;
   localparam int PRESCALE_LIMIT = 63;
   localparam int ITEMS_PER_PHASE = 250;

   // One result beat as the timer registers see it.
   typedef struct packed {
      status_type                status;
      logic [PRESCALE_W-1:0]     prescale;
      logic [PERIOD_W-1:0]       period_m1;
      logic [DCOUNT_W-1:0]       active_count;
   } timer_regs_type;

   // One row of the directed table; known rows carry their answer typed in.
   typedef struct {
      logic [FREQ_W-1:0] freq;
      logic [DUTY_W-1:0] duty;
      bit                known;
      timer_regs_type    regs;
   } stim_row_type;

   localparam timer_regs_type REJECT_ZERO  = '{STATUS_ZERO_FREQ, 6'd0, 10'd0, 11'd0};
   localparam timer_regs_type REJECT_ABOVE = '{STATUS_ABOVE_CLOCK, 6'd0, 10'd0, 11'd0};
   localparam timer_regs_type REJECT_RANGE = '{STATUS_PRESCALE_RANGE, 6'd0, 10'd0, 11'd0};
   localparam timer_regs_type NO_REGS      = '0;

   // Directed rows, all at the reset source clock of 12.8 MHz.
   localparam int DIRECTED_ROWS = 19;
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{32'd0,          17'd0,       1'b1, REJECT_ZERO},
      '{32'd0,          17'h1FFFF,   1'b1, REJECT_ZERO},
      '{32'hFFFFFFFF,   17'h10000,   1'b1, REJECT_ABOVE},
      '{32'd12800001,   17'd32768,   1'b1, REJECT_ABOVE},
      '{32'h80000000,   17'd1,       1'b1, REJECT_ABOVE},
      '{32'h55555555,   17'h0AAAA,   1'b1, REJECT_ABOVE},
      '{32'd12800000,   17'd65536,   1'b1, '{STATUS_OK, 6'd0, 10'd0, 11'd1}},
      '{32'd12800000,   17'd0,       1'b1, '{STATUS_OK, 6'd0, 10'd0, 11'd0}},
      '{32'd1,          17'd32768,   1'b1, REJECT_RANGE},
      '{32'd195,        17'h1FFFF,   1'b1, REJECT_RANGE},
      '{32'd196,        17'd65536,   1'b0, NO_REGS},
      '{32'd12500,      17'd65536,   1'b1, '{STATUS_OK, 6'd0, 10'd1023, 11'd1024}},
      '{32'd12500,      17'h1FFFF,   1'b1, '{STATUS_OK, 6'd0, 10'd1023, 11'd1024}},
      '{32'd12500,      17'd65535,   1'b0, NO_REGS},
      '{32'd12499,      17'd40000,   1'b0, NO_REGS},
      '{32'd12487,      17'd65536,   1'b0, NO_REGS},
      '{32'd6400000,    17'd32768,   1'b0, NO_REGS},
      '{32'd1000,       17'd1,       1'b0, NO_REGS},
      '{32'd20000,      17'h15555,   1'b0, NO_REGS}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [FREQ_W-1:0]      req_request_frequency = '0;
   logic [DUTY_W-1:0]      req_request_duty = '0;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PRESCALE_W-1:0]  rsp_prescale_value;
   logic [PERIOD_W-1:0]    rsp_period_minus_one;
   logic [DCOUNT_W-1:0]    rsp_duty_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [FREQ_W-1:0]      csr_source_clock_hz = '0;

   // Source clock the predictor assumes; follows every accepted register write.
   logic [FREQ_W-1:0]      clock_setting = CLOCK_RESET_HZ;
   timer_regs_type         pending_regs [$];
   int                     mismatch_count = 0;

   pwm_frequency_duty_to_registers #(
      .PERIOD_LIMIT   (PERIOD_LIMIT),
      .PRESCALE_LIMIT (PRESCALE_LIMIT)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_request_frequency(req_request_frequency),
      .req_request_duty     (req_request_duty),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_prescale_value   (rsp_prescale_value),
      .rsp_period_minus_one (rsp_period_minus_one),
      .rsp_duty_count       (rsp_duty_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_source_clock_hz  (csr_source_clock_hz)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out prescaler, period and duty count for one request.
   function automatic timer_regs_type compute_timer_regs(input logic [FREQ_W-1:0] freq,
                                                         input logic [DUTY_W-1:0] duty,
                                                         input logic [FREQ_W-1:0] hz);
      longint unsigned cycles;
      longint unsigned divider_m1;
      longint unsigned period;
      longint unsigned duty_sat;
      longint unsigned active;
      timer_regs_type  regs;
      regs = '0;
      if (freq == 0) begin
         regs.status = STATUS_ZERO_FREQ;
      end else if (freq > hz) begin
         regs.status = STATUS_ABOVE_CLOCK;
      end else begin
         cycles = longint'(hz) / longint'(freq);
         divider_m1 = (cycles - 1) / PERIOD_LIMIT;
         if (divider_m1 > PRESCALE_LIMIT) begin
            regs.status = STATUS_PRESCALE_RANGE;
         end else begin
            period = cycles / (divider_m1 + 1);
            if (period == 0) period = 1;
            if (period > PERIOD_LIMIT) period = PERIOD_LIMIT;
            // Duty above full scale saturates so the count never passes the period.
            duty_sat = (duty > DUTY_FULL) ? longint'(DUTY_FULL) : longint'(duty);
            active = (period * duty_sat) >> DUTY_FRAC_BITS;
            regs.status       = STATUS_OK;
            regs.prescale     = divider_m1[PRESCALE_W-1:0];
            regs.period_m1    = PERIOD_W'(period - 1);
            regs.active_count = active[DCOUNT_W-1:0];
         end
      end
      return regs;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Compare every result beat with the oldest outstanding expectation.
   always @(posedge clock) begin
      timer_regs_type want;
      if (!reset && rsp_strobe) begin
         if (pending_regs.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
         end else begin
            want = pending_regs.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_prescale_value !== want.prescale)
               report_mismatch($sformatf("prescale %0d, want %0d",
                                         rsp_prescale_value, want.prescale));
            if (rsp_period_minus_one !== want.period_m1)
               report_mismatch($sformatf("period-1 %0d, want %0d",
                                         rsp_period_minus_one, want.period_m1));
            if (rsp_duty_count !== want.active_count)
               report_mismatch($sformatf("duty count %0d, want %0d",
                                         rsp_duty_count, want.active_count));
         end
      end
   end

   // Present one request beat and hold it until the block takes it; start stays high.
   task automatic send_request(input logic [FREQ_W-1:0] freq, input logic [DUTY_W-1:0] duty,
                               input bit known, input timer_regs_type regs);
      start                 <= 1'b1;
      req_request_frequency <= freq;
      req_request_duty      <= duty;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (known) pending_regs.push_back(regs);
      else pending_regs.push_back(compute_timer_regs(freq, duty, clock_setting));
   endtask

   // Random idle burst on the request side.
   task automatic maybe_idle(input int gap_pct);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Register write, only once the block has drained.
   task automatic write_source_clock(input logic [FREQ_W-1:0] hz);
      start <= 1'b0;
      while (pending_regs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_source_clock_hz <= hz;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      clock_setting = hz;
   endtask

   // Frequencies aim mostly at a cycle count, so all prescalers and the range edge get hit.
   function automatic logic [FREQ_W-1:0] pick_frequency(input logic [FREQ_W-1:0] hz);
      logic [FREQ_W-1:0] target;
      logic [FREQ_W-1:0] freq;
      case ($urandom_range(0, 19))
         0: freq = '0;
         1, 2: freq = $urandom();
         3: freq = hz;
         4: freq = (hz == '1) ? $urandom() : hz + FREQ_W'($urandom_range(1, 5));
         default: begin
            case ($urandom_range(0, 3))
               0: target = $urandom_range(1, 2048);
               1: target = $urandom_range(60000, 70000);
               default: target = $urandom_range(1, 70000);
            endcase
            freq = hz / target;
            if (freq == 0) freq = 1;
         end
      endcase
      return freq;
   endfunction

   function automatic logic [DUTY_W-1:0] pick_duty();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DUTY_FULL;
         2: return DUTY_W'($urandom_range(65537, 131071));
         3: return DUTY_W'($urandom());
         default: return DUTY_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic run_random_phase(input logic [FREQ_W-1:0] hz, input int gap_pct);
      write_source_clock(hz);
      repeat (ITEMS_PER_PHASE) begin
         send_request(pick_frequency(clock_setting), pick_duty(), 1'b0, NO_REGS);
         maybe_idle(gap_pct);
      end
   endtask

   // Main sequence: reset, directed table, then random phases over several clocks.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_rows[i].freq, directed_rows[i].duty,
                      directed_rows[i].known, directed_rows[i].regs);
         maybe_idle(30);
      end

      run_random_phase(32'd12800000, 30);
      run_random_phase(32'd1, 60);
      run_random_phase(32'hFFFFFFFF, 20);
      run_random_phase(FREQ_W'($urandom_range(1000, 200000000)), 40);
      run_random_phase(32'd100000000, 30);
      // Last stretch runs with no idling at all.
      run_random_phase(CLOCK_RESET_HZ, 0);
      start <= 1'b0;

      while (pending_regs.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
